>>> rtl/core/kslt_pkg.sv
// Shared types and constants of the keyed sequential list table.
`timescale 1ns / 1ps
package kslt_pkg;

  localparam int KeyW    = 32;
  localparam int PayW    = 64;
  localparam int OpW     = 2;
  localparam int StatusW = 3;
  localparam int OutW    = 7;
  localparam int CapW    = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [OpW-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    IDX_TAG   = 2'd0,
    IDX_COUNT = 2'd1,
    IDX_ZERO  = 2'd2
  } idx_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     scan;
    logic     ins_write;
    logic     rd_last;
    logic     mv_write;
    logic     res_load;
    status_e  res_status;
    idx_sel_e res_idx_sel;
  } kslt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           full;
    logic           empty;
    logic           hit;
    logic           miss;
  } kslt_stat_t;

endpackage

>>> rtl/core/keyed_sequential_list_table_core.sv
// Top level of the keyed sequential list table: controller and datapath.
`timescale 1ns / 1ps
// An unsorted, packed table of unique 32-bit keys, each with a 64-bit payload.
// A request is offered on opcode_i, key_i and payload_i and is taken at a rising
// edge where start_i is high and busy_o is low. The opcode selects search, insert
// or remove; the unused code behaves as a search.
// Each request gives one result on status_o, index_o and count_o, shown for
// exactly one cycle with done_o high. The receiver cannot stall, so the result
// is simply taken in that cycle; a new request may be offered while it shows.
// The key store is scanned one entry a cycle through a registered read port,
// from slot 0 until a hit or the end of the list; a remove that hits then reads
// the last entry and writes it into the freed slot, and a full or empty refusal
// is given before any scan. busy_o is high from the accepting edge until the
// result shows.
// The capacity register is written through cfg_valid_i and cfg_data_i at any
// edge where cfg_valid_i is high (cfg_ready_o is always high); write it only
// while idle. Reset sets capacity to 64 and empties the table at once; the
// stores themselves are not cleared, as no slot is read before it is written.
module keyed_sequential_list_table_core #(
  parameter int DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kslt_pkg::CapW-1:0]    cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [kslt_pkg::OpW-1:0]     opcode_i,
  input  logic [kslt_pkg::KeyW-1:0]    key_i,
  input  logic [kslt_pkg::PayW-1:0]    payload_i,
  output logic                         done_o,
  output logic [kslt_pkg::StatusW-1:0] status_o,
  output logic [kslt_pkg::OutW-1:0]    index_o,
  output logic [kslt_pkg::OutW-1:0]    count_o
);
  import kslt_pkg::*;

  kslt_cmd_t  cmd;
  kslt_stat_t stat;

  // The capacity register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  kslt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  kslt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .payload_i   (payload_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .status_o    (status_o),
    .index_o     (index_o),
    .count_o     (count_o)
  );

endmodule

>>> rtl/core/kslt_ctrl.sv
// Controller state machine of the keyed sequential list table.
`timescale 1ns / 1ps
module kslt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  kslt_pkg::kslt_stat_t stat_i,
  output kslt_pkg::kslt_cmd_t  cmd_o,
  output logic               busy_o
);
  import kslt_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status  = ST_OK;
    cmd_o.res_idx_sel = IDX_TAG;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((stat_i.op == OP_INSERT) && stat_i.full) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_FULL;
          cmd_o.res_idx_sel = IDX_COUNT;
          state_d = S_IDLE;
        end else if ((stat_i.op == OP_REMOVE) && stat_i.empty) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_EMPTY;
          cmd_o.res_idx_sel = IDX_ZERO;
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          case (stat_i.op)
            OP_INSERT: begin
              cmd_o.res_load    = 1'b1;
              cmd_o.res_status  = ST_DUPLICATE;
              cmd_o.res_idx_sel = IDX_TAG;
              state_d = S_IDLE;
            end
            OP_REMOVE: begin
              state_d = S_MOVE_RD;
            end
            default: begin
              cmd_o.res_load    = 1'b1;
              cmd_o.res_status  = ST_OK;
              cmd_o.res_idx_sel = IDX_TAG;
              state_d = S_IDLE;
            end
          endcase
        end else if (stat_i.miss) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_idx_sel = IDX_COUNT;
          state_d = S_IDLE;
          if (stat_i.op == OP_INSERT) begin
            cmd_o.ins_write  = 1'b1;
            cmd_o.res_status = ST_OK;
          end else begin
            cmd_o.res_status = ST_NOT_FOUND;
          end
        end
      end
      S_MOVE_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.mv_write    = 1'b1;
        cmd_o.res_load    = 1'b1;
        cmd_o.res_status  = ST_OK;
        cmd_o.res_idx_sel = IDX_TAG;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/core/kslt_dp.sv
// Datapath of the keyed sequential list table: stores, scan pipeline, count and results.
`timescale 1ns / 1ps
module kslt_dp #(
  parameter int DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [kslt_pkg::CapW-1:0]     cfg_data_i,
  input  logic [kslt_pkg::OpW-1:0]      opcode_i,
  input  logic [kslt_pkg::KeyW-1:0]     key_i,
  input  logic [kslt_pkg::PayW-1:0]     payload_i,
  input  kslt_pkg::kslt_cmd_t           cmd_i,
  output kslt_pkg::kslt_stat_t          stat_o,
  output logic                          done_o,
  output logic [kslt_pkg::StatusW-1:0]  status_o,
  output logic [kslt_pkg::OutW-1:0]     index_o,
  output logic [kslt_pkg::OutW-1:0]     count_o
);
  import kslt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > OutW) ? CW : OutW;

  logic [KeyW-1:0] key_mem [DEPTH];
  logic [PayW-1:0] pay_mem [DEPTH];

  logic [CapW-1:0]    cap_q;
  logic [CW-1:0]      count_q, count_d;
  logic [OpW-1:0]     op_q;
  logic [KeyW-1:0]    key_q;
  logic [PayW-1:0]    pay_q;
  logic [CW-1:0]      scan_ptr_q;
  logic               pend_q;
  logic [AW-1:0]      tag_q;
  logic [KeyW-1:0]    key_rd_q;
  logic [PayW-1:0]    pay_rd_q;
  logic               done_q;
  logic [StatusW-1:0] status_q;
  logic [OutW-1:0]    index_q;
  logic [OutW-1:0]    count_out_q;

  logic               hit, issue;
  logic [CW-1:0]      last;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               we;
  logic [KeyW-1:0]    wr_key;
  logic [PayW-1:0]    wr_pay;
  logic [MW-1:0]      idx_full, count_full;

  assign hit   = pend_q && (key_rd_q == key_q);
  assign issue = cmd_i.scan && (scan_ptr_q < count_q) && !hit;
  assign last  = count_q - CW'(1);

  assign stat_o.op    = op_q;
  assign stat_o.full  = (count_q >= CW'(DEPTH)) || (MW'(count_q) >= MW'(cap_q));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.hit   = hit;
  assign stat_o.miss  = !hit && !pend_q && !issue;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CapReset;
      count_q    <= '0;
      scan_ptr_q <= '0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
      if (cmd_i.capture) begin
        scan_ptr_q <= '0;
      end else if (issue) begin
        scan_ptr_q <= scan_ptr_q + CW'(1);
      end
      pend_q <= issue;
      done_q <= cmd_i.res_load;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_write) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.mv_write) begin
      count_d = last;
    end
  end

  // Request and scan payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      pay_q <= payload_i;
    end
    if (issue) begin
      tag_q <= scan_ptr_q[AW-1:0];
    end
  end

  assign rd_addr = cmd_i.rd_last ? last[AW-1:0] : scan_ptr_q[AW-1:0];
  assign we      = cmd_i.ins_write || cmd_i.mv_write;
  assign wr_addr = cmd_i.mv_write ? tag_q : count_q[AW-1:0];
  assign wr_key  = cmd_i.mv_write ? key_rd_q : key_q;
  assign wr_pay  = cmd_i.mv_write ? pay_rd_q : pay_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    key_rd_q <= key_mem[rd_addr];
    pay_rd_q <= pay_mem[rd_addr];
  end

  // Result registers.
  always_comb begin
    case (cmd_i.res_idx_sel)
      IDX_TAG:   idx_full = MW'(tag_q);
      IDX_COUNT: idx_full = MW'(count_q);
      default:   idx_full = '0;
    endcase
    count_full = MW'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q    <= cmd_i.res_status;
      index_q     <= idx_full[OutW-1:0];
      count_out_q <= count_full[OutW-1:0];
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign index_o  = index_q;
  assign count_o  = count_out_q;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the keyed sequential list table core.
`timescale 1ns / 1ps
module tb_top;
  import kslt_pkg::*;

  // The table is built with its default depth; the predictor mirrors it.
  localparam int Depth      = 64;
  // Far above the slowest correct run: about a thousand requests, each at most
  // one full scan and a move, plus the sender's longest gaps and the drains.
  localparam int CycleLimit = 400000;
  // Random keys come mostly from a pool a little larger than the table, so that
  // hits, duplicates, misses and a completely full table all occur often.
  localparam int KeyPool    = 80;
  localparam int PrintLimit = 40;
  // The fourth opcode is not decoded by the block and behaves as a search.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    status_e         st;
    logic [OutW-1:0] idx;
    logic [OutW-1:0] cnt;
  } table_result_t;

  // One line of the directed script: either a request or a capacity write.
  // Where the outcome is obvious by inspection it is typed in, otherwise the
  // predictor supplies it.
  typedef struct packed {
    row_kind_e       kind;
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
    logic [CapW-1:0] cap;
    logic            typed;
    table_result_t   want;
  } script_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CapW-1:0]     cfg_data_i;
  logic                start_i;
  logic                busy_o;
  logic [OpW-1:0]      opcode_i;
  logic [KeyW-1:0]     key_i;
  logic [PayW-1:0]     payload_i;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [OutW-1:0]     index_o;
  logic [OutW-1:0]     count_o;

  // Predictor state: the packed list of keys, the number of entries and the
  // capacity register. Payloads are never reported, so they are not kept.
  logic [KeyW-1:0]     table_keys [Depth];
  int unsigned         table_fill = 0;
  logic [CapW-1:0]     table_cap  = CapReset;

  logic [KeyW-1:0]     key_pool [KeyPool];
  table_result_t       pending_results [$];
  int unsigned         send_idle_pct = 0;
  int unsigned         error_count   = 0;
  int unsigned         cycle_count   = 0;

  keyed_sequential_list_table_core #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .opcode_i   (opcode_i),
    .key_i      (key_i),
    .payload_i  (payload_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .index_o    (index_o),
    .count_o    (count_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (error_count < PrintLimit) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    error_count++;
  endtask

  // Applies one request to the predictor state and returns the result that the
  // block must report for it. The scan stops at the first matching slot below
  // the count; a miss leaves the position at the count itself.
  function automatic table_result_t apply_request(logic [OpW-1:0] op,
                                                  logic [KeyW-1:0] key);
    table_result_t res;
    int unsigned   eff_cap;
    int unsigned   pos;
    int unsigned   last;
    eff_cap = (int'(table_cap) < Depth) ? int'(table_cap) : Depth;
    pos = table_fill;
    for (int i = 0; i < int'(table_fill); i++) begin
      if (pos == table_fill && table_keys[i] == key) begin
        pos = i;
      end
    end
    res.st  = ST_OK;
    res.idx = '0;
    case (op)
      OP_INSERT: begin
        // A full table is refused before the duplicate check is looked at.
        if (table_fill >= eff_cap) begin
          res.st  = ST_FULL;
          res.idx = table_fill[OutW-1:0];
        end else if (pos < table_fill) begin
          res.st  = ST_DUPLICATE;
          res.idx = pos[OutW-1:0];
        end else begin
          table_keys[table_fill] = key;
          res.idx = table_fill[OutW-1:0];
          table_fill++;
        end
      end
      OP_REMOVE: begin
        if (table_fill == 0) begin
          res.st = ST_EMPTY;
        end else if (pos < table_fill) begin
          // The last entry fills the hole so that the list stays packed.
          last = table_fill - 1;
          table_keys[pos] = table_keys[last];
          table_fill = last;
          res.idx = pos[OutW-1:0];
        end else begin
          res.st  = ST_NOT_FOUND;
          res.idx = table_fill[OutW-1:0];
        end
      end
      default: begin
        res.idx = pos[OutW-1:0];
        if (pos >= table_fill) begin
          res.st = ST_NOT_FOUND;
        end
      end
    endcase
    res.cnt = table_fill[OutW-1:0];
    return res;
  endfunction

  // Result checker. done_o is sampled at the edge that ends its cycle, as the
  // block cannot be held off; each result is matched to the oldest request.
  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", status_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.st) begin
          report_mismatch("status", status_o, want.st);
        end
        if (index_o !== want.idx) begin
          report_mismatch("index", index_o, want.idx);
        end
        if (count_o !== want.cnt) begin
          report_mismatch("count", count_o, want.cnt);
        end
      end
    end
  end

  // Offers one request, after a random gap, and returns once it is taken.
  // start_i is left high so that back-to-back requests follow without a gap.
  task automatic send_request(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                              input logic [PayW-1:0] pay, output table_result_t predicted);
    if ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    start_i   <= 1'b1;
    opcode_i  <= op;
    key_i     <= key;
    payload_i <= pay;
    do @(posedge clk_i); while (busy_o);
    predicted = apply_request(op, key);
  endtask

  // Stops offering and waits until every outstanding result has been seen
  // and the block has gone idle. The condition is tested only on the clock, never at the call.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy_o);
  endtask

  // The capacity register is only written while the table is idle.
  task automatic write_capacity(logic [CapW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    table_cap = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(99) < 5) begin
      return $urandom();
    end
    return key_pool[$urandom_range(KeyPool - 1)];
  endfunction

  // A phase of random traffic under one capacity setting. ins_pct sets how
  // strongly the mix pushes the table towards full; the remainder is split
  // between searches and removes, with a little of the undecoded opcode.
  task automatic run_phase(logic [CapW-1:0] cap, int unsigned items,
                           int unsigned idle_pct, int unsigned ins_pct);
    table_result_t   predicted;
    logic [OpW-1:0]  op;
    int unsigned     roll;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    repeat (items) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        op = OpUnused;
      end else if (roll < 4 + ins_pct) begin
        op = OP_INSERT;
      end else if (roll[0]) begin
        op = OP_REMOVE;
      end else begin
        op = OP_SEARCH;
      end
      // Now and then the sender holds back until the table has caught up.
      if ($urandom_range(49) == 0) begin
        wait_drained();
      end
      send_request(op, pick_key(), {$urandom(), $urandom()}, predicted);
      pending_results.push_back(predicted);
    end
  endtask

  function automatic script_row_t req_row(logic [OpW-1:0] op, logic [KeyW-1:0] key,
                                          logic [PayW-1:0] pay);
    script_row_t row;
    row         = '0;
    row.kind    = ROW_REQ;
    row.op      = op;
    row.key     = key;
    row.payload = pay;
    return row;
  endfunction

  function automatic script_row_t checked_row(logic [OpW-1:0] op, logic [KeyW-1:0] key,
                                              logic [PayW-1:0] pay, status_e st,
                                              int unsigned idx, int unsigned cnt);
    script_row_t row;
    row          = req_row(op, key, pay);
    row.typed    = 1'b1;
    row.want.st  = st;
    row.want.idx = idx[OutW-1:0];
    row.want.cnt = cnt[OutW-1:0];
    return row;
  endfunction

  function automatic script_row_t cap_row(logic [CapW-1:0] cap);
    script_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.cap  = cap;
    return row;
  endfunction

  initial begin : stimulus
    script_row_t   script [$];
    table_result_t predicted;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    start_i     = 1'b0;
    opcode_i    = OP_SEARCH;
    key_i       = '0;
    payload_i   = '0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KeyPool; i++) begin
      key_pool[i] = $urandom();
    end

    // Directed script. The first rows run on the reset capacity of 64: an
    // empty table, both key extremes, a duplicate and removes that move the
    // last entry into the freed slot. Then the capacity is set equal to the
    // count, so that an insert of a key already present reports full rather
    // than duplicate; then to zero, where a remove takes the last slot itself
    // and every insert is refused; then above the table depth.
    script.push_back(checked_row(OP_SEARCH, 32'h0, '0, ST_NOT_FOUND, 0, 0));
    script.push_back(checked_row(OP_REMOVE, 32'hFFFF_FFFF, '1, ST_EMPTY, 0, 0));
    script.push_back(checked_row(OpUnused, 32'h5, '0, ST_NOT_FOUND, 0, 0));
    script.push_back(checked_row(OP_INSERT, 32'h0, '0, ST_OK, 0, 1));
    script.push_back(checked_row(OP_INSERT, 32'hFFFF_FFFF, '1, ST_OK, 1, 2));
    script.push_back(checked_row(OP_INSERT, 32'h0, 64'h0123_4567_89AB_CDEF,
                                 ST_DUPLICATE, 0, 2));
    script.push_back(checked_row(OP_SEARCH, 32'hFFFF_FFFF, '0, ST_OK, 1, 2));
    script.push_back(checked_row(OP_SEARCH, 32'h1234_5678, '0, ST_NOT_FOUND, 2, 2));
    script.push_back(req_row(OP_INSERT, 32'h1234_5678, 64'hA5A5_A5A5_5A5A_5A5A));
    script.push_back(req_row(OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001));
    script.push_back(checked_row(OP_REMOVE, 32'h0, '0, ST_OK, 0, 3));
    script.push_back(req_row(OP_SEARCH, 32'h8000_0000, '1));
    script.push_back(checked_row(OP_REMOVE, 32'h0, '0, ST_NOT_FOUND, 3, 3));
    script.push_back(req_row(OpUnused, 32'h1234_5678, '1));
    script.push_back(req_row(OP_REMOVE, 32'h8000_0000, '0));
    script.push_back(cap_row(7'd2));
    script.push_back(checked_row(OP_INSERT, 32'hFFFF_FFFF, '1, ST_FULL, 2, 2));
    script.push_back(checked_row(OP_INSERT, 32'h7, '0, ST_FULL, 2, 2));
    script.push_back(cap_row(7'd0));
    script.push_back(req_row(OP_SEARCH, 32'hFFFF_FFFF, '0));
    script.push_back(req_row(OP_REMOVE, 32'hFFFF_FFFF, '0));
    script.push_back(checked_row(OP_INSERT, 32'h9, '1, ST_FULL, 1, 1));
    script.push_back(cap_row(7'd127));
    script.push_back(req_row(OP_INSERT, 32'h9, 64'h5555_5555_AAAA_AAAA));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 7;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        write_capacity(script[i].cap);
      end else begin
        send_request(script[i].op, script[i].key, script[i].payload, predicted);
        if (script[i].typed) begin
          pending_results.push_back(script[i].want);
        end else begin
          pending_results.push_back(predicted);
        end
      end
    end

    // Random traffic. The sender first idles rarely, then often, then never.
    // The capacity walks from above the depth (the table really fills to 64),
    // to well below the count, to zero and one, then a random middle value,
    // back to the reset value and finally to a tiny table.
    run_phase(7'd127, 200, 7, 60);
    run_phase(7'd20, 150, 7, 40);
    run_phase(7'd0, 50, 65, 30);
    run_phase(7'd1, 100, 65, 50);
    run_phase(CapW'($urandom_range(2, 63)), 150, 65, 45);
    run_phase(CapReset, 250, 0, 55);
    run_phase(7'd2, 100, 0, 50);

    // Let every outstanding request complete, then leave room for any stray
    // result that would come after the last one expected.
    wait_drained();
    repeat (Depth + 10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/kslt_pkg.sv
rtl/core/kslt_ctrl.sv
rtl/core/kslt_dp.sv
rtl/core/keyed_sequential_list_table_core.sv
tb/tb_top.sv
